FILE: design/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg: shared definitions for the sorted table binary search block
// Table geometry, bound widths, item kind codes and the controller states.
// ----------------------------------------------------------------------------
package stbs_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int KEY_WIDTH   = 32;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Fixed port widths
    localparam int INDEX_W      = 8;
    localparam int PORT_KEY_W   = 32;
    localparam int RANGE_HIGH_W = 9;

    // Signed search bounds: room for range_high, the depth and one step past it
    localparam int BASE_W  = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;
    localparam int BOUND_W = BASE_W + 2;

    // Item kind codes
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_EMIT
    } state_t;

endpackage

FILE: design/sorted_table_binary_search_top.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top: binary search over a loaded key table
// Operation: a load beat writes one table entry and gives no result. A search
//   reads one entry per probe and compares it in ST_PROBE, log2(depth) + 1
//   probes at most for a 256-entry table; an empty range goes straight to ST_EMIT.
// Throughput: one item at a time; s_ready stays low until the result enters the output register.
// Reset: aresetn (synchronous, active low) clears the controller and the
//   result valid; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [7:0]  s_entry_index,
    input  logic signed [31:0] s_entry_key,
    input  logic signed [31:0] s_search_key,
    input  logic [7:0]  s_range_low,
    input  logic signed [8:0]  s_range_high,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [7:0]  m_match_index
);

    localparam int AW = stbs_pkg::ADDR_W;
    localparam int BW = stbs_pkg::BOUND_W;
    localparam int KW = stbs_pkg::KEY_WIDTH;

    stbs_pkg::state_t state_reg, state_next;

    // Search context
    logic signed [BW-1:0] lo_reg, lo_next;
    logic signed [BW-1:0] hi_reg, hi_next;
    logic [AW-1:0]        mid_reg, mid_next;
    logic signed [KW-1:0] key_reg, key_next;

    // Finished result parked while the output register is still full
    logic       res_found_reg, res_found_next;
    logic [7:0] res_index_reg, res_index_next;

    // Output register
    logic       m_valid_reg, m_valid_next;
    logic       m_found_reg, m_found_next;
    logic [7:0] m_index_reg, m_index_next;

    // Table port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [KW-1:0] ram_wdata;
    logic          ram_re;
    logic [KW-1:0] ram_rdata;

    // Control decode
    logic s_beat;
    logic load_beat;
    logic search_beat;
    logic out_free;
    logic probe_hit;
    logic probe_gt;
    logic probe_done;
    logic out_load;

    // Candidate bounds for the next probe and their midpoint
    logic signed [BW-1:0] cand_lo;
    logic signed [BW-1:0] cand_hi;
    logic signed [BW-1:0] cand_sum;
    logic                 cand_ok;
    logic signed [BW-1:0] hi_in;

    stbs_ram #(
        .WIDTH (KW),
        .DEPTH (stbs_pkg::TABLE_DEPTH)
    ) u_key_table (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (mid_next),
        .rdata (ram_rdata)
    );

    assign s_beat      = s_valid && s_ready;
    assign load_beat   = s_beat && (s_kind == stbs_pkg::KIND_LOAD);
    assign search_beat = s_beat && (s_kind == stbs_pkg::KIND_SEARCH);
    assign out_free    = !m_valid_reg || m_ready;

    // Probe compare against the entry read last cycle (signed order)
    assign probe_hit  = ($signed(ram_rdata) == key_reg);
    assign probe_gt   = ($signed(ram_rdata) > key_reg);
    assign probe_done = probe_hit || !cand_ok;

    // range_high saturated to the last table entry
    always_comb begin
        hi_in = BW'(s_range_high);
        if (hi_in > BW'(stbs_pkg::TABLE_DEPTH - 1)) begin
            hi_in = BW'(stbs_pkg::TABLE_DEPTH - 1);
        end
    end

    // Bounds for the next probe: from the input beat in idle, else halved
    always_comb begin
        cand_lo = lo_reg;
        cand_hi = hi_reg;
        if (state_reg == stbs_pkg::ST_IDLE) begin
            cand_lo = BW'(s_range_low);
            cand_hi = hi_in;
        end else if (probe_gt) begin
            cand_hi = BW'(mid_reg) - BW'(1);
        end else begin
            cand_lo = BW'(mid_reg) + BW'(1);
        end
        cand_ok  = (cand_lo <= cand_hi);
        // both bounds are non-negative whenever cand_ok holds
        cand_sum = cand_lo + cand_hi;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            stbs_pkg::ST_IDLE: begin
                if (search_beat) begin
                    state_next = cand_ok ? stbs_pkg::ST_PROBE : stbs_pkg::ST_EMIT;
                end
            end
            stbs_pkg::ST_PROBE: begin
                if (probe_done) begin
                    state_next = out_free ? stbs_pkg::ST_IDLE : stbs_pkg::ST_EMIT;
                end
            end
            stbs_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = stbs_pkg::ST_IDLE;
                end
            end
            default: state_next = stbs_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb begin
        s_ready   = (state_reg == stbs_pkg::ST_IDLE);
        ram_we    = load_beat &&
                    ({24'd0, s_entry_index} < 32'(stbs_pkg::TABLE_DEPTH));
        ram_waddr = AW'(s_entry_index);
        ram_wdata = KW'(s_entry_key);
        ram_re    = 1'b0;

        lo_next        = cand_lo;
        hi_next        = cand_hi;
        mid_next       = AW'(cand_sum >>> 1);
        key_next       = key_reg;
        res_found_next = res_found_reg;
        res_index_next = res_index_reg;
        out_load       = 1'b0;
        m_found_next   = m_found_reg;
        m_index_next   = m_index_reg;

        unique case (state_reg)
            stbs_pkg::ST_IDLE: begin
                key_next       = KW'(s_search_key);
                ram_re         = search_beat && cand_ok;
                res_found_next = 1'b0;
                res_index_next = '0;
            end
            stbs_pkg::ST_PROBE: begin
                ram_re         = !probe_done;
                res_found_next = probe_hit;
                res_index_next = probe_hit ? 8'(mid_reg) : 8'd0;
                if (probe_done && out_free) begin
                    out_load     = 1'b1;
                    m_found_next = probe_hit;
                    m_index_next = probe_hit ? 8'(mid_reg) : 8'd0;
                end
            end
            stbs_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    m_found_next = res_found_reg;
                    m_index_next = res_index_reg;
                end
            end
            default: ;
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= stbs_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        if (ram_re) begin
            mid_reg <= mid_next;
        end
        key_reg       <= key_next;
        res_found_reg <= res_found_next;
        res_index_reg <= res_index_next;
        m_found_reg   <= m_found_next;
        m_index_reg   <= m_index_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_match_index = m_index_reg;

endmodule

FILE: design/stbs_ram.sv
// ----------------------------------------------------------------------------
// stbs_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; read data is registered and holds while
// no read is enabled.
// ----------------------------------------------------------------------------
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/stbs_checker.sv
// ----------------------------------------------------------------------------
// stbs_checker: port-level checks for the binary search block
// Watches the two channels only; bound to the top level below.
// ----------------------------------------------------------------------------
module stbs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_kind,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_found,
    input logic [7:0] m_match_index
);

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found) && $stable(m_match_index))
        else $error("result beat changed while stalled");

    // Miss reports index zero
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_match_index == 8'd0)
        else $error("miss with nonzero index");

    // A load never makes a result
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_kind == stbs_pkg::KIND_LOAD && !m_valid |=> !m_valid)
        else $error("result after load beat");

    // One search at a time
    a_search_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_kind == stbs_pkg::KIND_SEARCH |=> !s_ready)
        else $error("input ready right after search beat");

    // Reset empties the output
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind sorted_table_binary_search_top stbs_checker u_stbs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_kind        (s_kind),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_found       (m_found),
    .m_match_index (m_match_index)
);

FILE: sim/tb_sorted_table_binary_search_top.sv
// ----------------------------------------------------------------------------
// tb_sorted_table_binary_search_top: self-checking bench for the key table search
// Loads a full ascending table, then runs directed searches (table ends, misses,
// empty and single-entry ranges, an out-of-order entry, duplicate keys). The
// random part follows: segment reloads that keep the table sorted, some noise
// and out-of-order writes, and searches with hit-biased keys over varied ranges.
// Every result is checked against a local search over a mirror of the table.
// ----------------------------------------------------------------------------
module tb_sorted_table_binary_search_top;

    localparam int STALL_LIMIT  = 5000;  // cycles with no beat on either channel
    localparam int RANDOM_ITEMS = 270;
    localparam int DRAIN_CYCLES = 12;    // idle wait after the last answer is in
    localparam int IDLE_PCT     = 21;

    // One input beat, every field carried whether the block uses it or not
    typedef struct {
        logic               kind;
        logic [7:0]         entry_index;
        logic signed [31:0] entry_key;
        logic signed [31:0] search_key;
        logic [7:0]         range_low;
        logic signed [8:0]  range_high;
    } table_op_t;

    // One search answer
    typedef struct {
        logic       found;
        logic [7:0] index;
    } lookup_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_kind;
    logic [7:0]         s_entry_index;
    logic signed [31:0] s_entry_key;
    logic signed [31:0] s_search_key;
    logic [7:0]         s_range_low;
    logic signed [8:0]  s_range_high;
    logic               m_valid;
    logic               m_ready;
    logic               m_found;
    logic [7:0]         m_match_index;

    // Stimulus side: pending beats and the table as the generator sees it
    table_op_t          op_queue [$];
    table_op_t          next_op;
    logic signed [31:0] gen_keys [stbs_pkg::TABLE_DEPTH];
    int                 ops_issued;
    logic               quiet_stretch;

    // Checking side: table as the block should hold it, and answers owed
    logic signed [31:0] key_mirror [stbs_pkg::TABLE_DEPTH];
    lookup_t            lookup_q [$];
    lookup_t            owed;
    logic               in_taken;
    int                 stall_run;
    int                 fail_count;
    int                 load_beats;
    int                 search_beats;
    int                 hit_count;
    int                 miss_count;

    sorted_table_binary_search_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_entry_index (s_entry_index),
        .s_entry_key   (s_entry_key),
        .s_search_key  (s_search_key),
        .s_range_low   (s_range_low),
        .s_range_high  (s_range_high),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_match_index (m_match_index)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // A window of beats where neither side ever idles, so back-to-back
    // searches and loads run at full rate for a while.
    assign quiet_stretch = (ops_issued >= 320) && (ops_issued < 470);

    // Binary search over the mirror: truncated midpoint, empty test before
    // each probe, range_high saturated to the last entry.
    function automatic lookup_t search_table(input logic signed [31:0] key,
                                             input logic [7:0] lo_in,
                                             input logic signed [8:0] hi_in);
        int      lo;
        int      hi;
        int      mid;
        lookup_t res;
        lo = lo_in;
        hi = hi_in;
        if (hi > stbs_pkg::TABLE_DEPTH - 1)
            hi = stbs_pkg::TABLE_DEPTH - 1;
        res.found = 1'b0;
        res.index = '0;
        while (lo <= hi && !res.found) begin
            mid = (lo + hi) / 2;
            if (key_mirror[mid] == key) begin
                res.found = 1'b1;
                res.index = mid[7:0];
            end else if (key_mirror[mid] > key) begin
                hi = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        return res;
    endfunction

    // Queue a load; the search fields carry noise the block must ignore
    task automatic push_load(input int idx, input logic signed [31:0] key);
        table_op_t op;
        op.kind        = stbs_pkg::KIND_LOAD;
        op.entry_index = idx[7:0];
        op.entry_key   = key;
        op.search_key  = $urandom;
        op.range_low   = $urandom;
        op.range_high  = $urandom;
        gen_keys[idx[7:0]] = key;
        op_queue.push_back(op);
    endtask

    // Queue a search; the load fields carry noise
    task automatic push_search(input logic signed [31:0] key, input int lo,
                               input int hi);
        table_op_t op;
        op.kind        = stbs_pkg::KIND_SEARCH;
        op.entry_index = $urandom;
        op.entry_key   = $urandom;
        op.search_key  = key;
        op.range_low   = lo[7:0];
        op.range_high  = hi[8:0];
        op_queue.push_back(op);
    endtask

    // Driver: presents beats at the falling edge, holds a beat until taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || in_taken) begin
                if (op_queue.size() > 0 &&
                    (quiet_stretch || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    next_op = op_queue.pop_front();
                    s_valid       <= 1'b1;
                    s_kind        <= next_op.kind;
                    s_entry_index <= next_op.entry_index;
                    s_entry_key   <= next_op.entry_key;
                    s_search_key  <= next_op.search_key;
                    s_range_low   <= next_op.range_low;
                    s_range_high  <= next_op.range_high;
                    ops_issued    <= ops_issued + 1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= quiet_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Monitor: at the rising edge, check an accepted result first, then
    // record an accepted input beat (a result never answers the beat taken
    // at the same edge).
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_taken  <= 1'b0;
            stall_run <= 0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (lookup_q.size() == 0) begin
                    $error("result beat with no search outstanding: found %0d index %0d",
                           m_found, m_match_index);
                    fail_count++;
                end else begin
                    owed = lookup_q.pop_front();
                    if (m_found !== owed.found) begin
                        $error("found: expected %0d, actual %0d", owed.found, m_found);
                        fail_count++;
                    end
                    if (m_match_index !== owed.index) begin
                        $error("match_index: expected %0d, actual %0d",
                               owed.index, m_match_index);
                        fail_count++;
                    end
                    if (owed.found)
                        hit_count++;
                    else
                        miss_count++;
                end
            end
            if (s_valid && s_ready) begin
                if (s_kind == stbs_pkg::KIND_LOAD) begin
                    if (s_entry_index < stbs_pkg::TABLE_DEPTH)
                        key_mirror[s_entry_index] = s_entry_key;
                    load_beats++;
                end else begin
                    lookup_q.push_back(search_table(s_search_key, s_range_low,
                                                    s_range_high));
                    search_beats++;
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_run <= 0;
            else
                stall_run <= stall_run + 1;
        end
    end

    // Watchdog: too long without any beat means the block is hung
    initial begin
        while (stall_run < STALL_LIMIT)
            @(negedge aclk);
        $display("tb_sorted_table_binary_search_top failed");
        $finish;
    end

    // Stimulus and end of run
    initial begin
        int                 i;
        int                 j;
        int                 n;
        int                 a;
        int                 b;
        int                 lo_i;
        int                 hi_i;
        int                 idx;
        int                 pick;
        int                 random_ops;
        longint             acc;
        longint             lowb;
        longint             highb;
        longint             span;
        longint             tmp;
        longint             seg [16];
        logic [63:0]        rnd;
        logic signed [31:0] key;
        logic signed [31:0] saved;

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_kind        = stbs_pkg::KIND_LOAD;
        s_entry_index = '0;
        s_entry_key   = '0;
        s_search_key  = '0;
        s_range_low   = '0;
        s_range_high  = '0;
        m_ready       = 1'b0;
        in_taken      = 1'b0;
        stall_run     = 0;
        ops_issued    = 0;
        fail_count    = 0;
        load_beats    = 0;
        search_beats  = 0;
        hit_count     = 0;
        miss_count    = 0;

        // Fill every entry in ascending order before any search, so no
        // probe can land on an unwritten entry. Both key extremes sit at
        // the table ends; an occasional zero step makes duplicates.
        acc = -64'sd2147483648;
        push_load(0, acc[31:0]);
        for (i = 1; i < stbs_pkg::TABLE_DEPTH - 1; i++) begin
            if ($urandom_range(0, 15) != 0)
                acc += $urandom_range(1, 16000000);
            if (acc > 64'sd2147483646)
                acc = 64'sd2147483646;
            push_load(i, acc[31:0]);
        end
        push_load(stbs_pkg::TABLE_DEPTH - 1, 32'sh7fff_ffff);

        // Directed searches: both extremes, the first probe, misses
        push_search(gen_keys[0], 0, 255);
        push_search(gen_keys[255], 0, 255);
        push_search(gen_keys[127], 0, 255);
        push_search(gen_keys[100] + 1, 0, 255);
        push_search(gen_keys[0], 1, 255);
        push_search(gen_keys[200], 0, 50);
        // empty ranges, including negative range_high down to the minimum
        push_search(gen_keys[10], 10, 9);
        push_search(gen_keys[0], 0, -1);
        push_search(gen_keys[255], 255, -256);
        push_search(gen_keys[150], 200, 100);
        // single-entry ranges at both ends
        push_search(gen_keys[0], 0, 0);
        push_search(gen_keys[255], 255, 255);
        push_search(gen_keys[255] - 1, 255, 255);
        // one entry out of order: the search follows the same probes anyway
        saved = gen_keys[128];
        push_load(128, 32'sh7fff_ffff);
        push_search(32'sh7fff_ffff, 0, 255);
        push_search(saved, 0, 255);
        push_search(gen_keys[129], 0, 255);
        push_load(128, saved);
        // duplicate keys side by side
        push_load(50, gen_keys[51]);
        push_search(gen_keys[51], 0, 255);
        push_search(gen_keys[51], 50, 50);

        // Random part: mostly searches over a table kept sorted by segment
        // reloads, with a little noise and some reversed segments.
        random_ops = 0;
        while (random_ops < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 14) begin
                // rewrite a segment with keys that fit between its neighbors
                a = $urandom_range(0, stbs_pkg::TABLE_DEPTH - 1);
                n = $urandom_range(1, 16);
                b = (a + n - 1 > stbs_pkg::TABLE_DEPTH - 1) ? stbs_pkg::TABLE_DEPTH - 1
                                                             : a + n - 1;
                n = b - a + 1;
                lowb  = (a > 0) ? longint'(gen_keys[a - 1]) : -64'sd2147483648;
                highb = (b < stbs_pkg::TABLE_DEPTH - 1) ? longint'(gen_keys[b + 1])
                                                        : 64'sd2147483647;
                if (lowb > highb) begin
                    tmp   = lowb;
                    lowb  = highb;
                    highb = tmp;
                end
                span = highb - lowb + 1;
                for (j = 0; j < n; j++) begin
                    rnd    = {$urandom, $urandom};
                    seg[j] = lowb + longint'(rnd % span);
                end
                for (i = 1; i < n; i++) begin
                    tmp = seg[i];
                    j   = i - 1;
                    while (j >= 0 && seg[j] > tmp) begin
                        seg[j + 1] = seg[j];
                        j--;
                    end
                    seg[j + 1] = tmp;
                end
                // one in five goes in descending order and breaks the sort
                if ($urandom_range(0, 4) == 0) begin
                    for (j = 0; j < n; j++)
                        push_load(a + j, seg[n - 1 - j][31:0]);
                end else begin
                    for (j = 0; j < n; j++)
                        push_load(a + j, seg[j][31:0]);
                end
                random_ops += n;
            end else if (pick < 17) begin
                push_load($urandom_range(0, stbs_pkg::TABLE_DEPTH - 1), $urandom);
                random_ops++;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    lo_i = 0;
                    hi_i = 255;
                end else if (pick < 65) begin
                    lo_i = $urandom_range(0, 255);
                    hi_i = $urandom_range(lo_i, 255);
                end else if (pick < 75) begin
                    lo_i = $urandom_range(0, 255);
                    if (lo_i == 0 || $urandom_range(0, 1) == 0)
                        hi_i = -int'($urandom_range(1, 256));
                    else
                        hi_i = $urandom_range(0, lo_i - 1);
                end else if (pick < 87) begin
                    lo_i = 0;
                    hi_i = $urandom_range(0, 255);
                end else begin
                    lo_i = $urandom_range(0, 255);
                    hi_i = 255;
                end
                idx  = (hi_i >= lo_i) ? int'($urandom_range(lo_i, hi_i))
                                      : int'($urandom_range(0, 255));
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    key = gen_keys[idx];
                else if (pick < 70)
                    key = gen_keys[idx] + ($urandom_range(0, 1) ? 1 : -1);
                else if (pick < 78)
                    key = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
                else
                    key = $urandom;
                push_search(key, lo_i, hi_i);
                random_ops++;
            end
        end

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Drain: every beat taken, every answer in, then DRAIN_CYCLES idle cycles
        // so a stray result beat would still be caught.
        while (op_queue.size() != 0 || s_valid)
            @(negedge aclk);
        while (lookup_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (lookup_q.size() != 0) begin
            $error("%0d search answers never arrived", lookup_q.size());
            fail_count++;
        end

        $display("Covered %0d load beats and %0d searches (%0d found, %0d not found)",
                 load_beats, search_beats, hit_count, miss_count);
        $display("Errors: %0d", fail_count);
        if (fail_count == 0) begin
            $display("tb_sorted_table_binary_search_top passed");
        end else begin
            $display("tb_sorted_table_binary_search_top failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/stbs_pkg.sv
design/stbs_ram.sv
design/sorted_table_binary_search_top.sv
design/stbs_checker.sv
sim/tb_sorted_table_binary_search_top.sv
